>>> rtl/av_bv_id_codec_assert.svh
// Assertion macros for the av/BV ID codec.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef AV_BV_ID_CODEC_ASSERT_SVH
`define AV_BV_ID_CODEC_ASSERT_SVH

// checked only outside reset
`define AVBV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define AVBV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/avbv_pkg.sv
// Shared constants, alphabet lookups and result types for the av/BV ID codec.
// No dependencies.
package avbv_pkg;

  localparam logic [33:0] KEY_XOR = 34'd177451812;
  localparam logic [34:0] KEY_ADD = 35'd8728348608;
  localparam int unsigned NUM_SYMS = 58;

  // powers of the radix
  localparam logic [35:0] RADIX_P1 = 36'd58;
  localparam logic [35:0] RADIX_P2 = 36'd3364;
  localparam logic [35:0] RADIX_P3 = 36'd195112;
  localparam logic [35:0] RADIX_P4 = 36'd11316496;
  localparam logic [35:0] RADIX_P5 = 36'd656356768;

  // first symbol sits in the top byte
  localparam logic [NUM_SYMS-1:0][7:0] ALPHABET =
    "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";

  typedef struct packed {
    logic       hit;
    logic [5:0] digit;
  } sym_t;

  typedef struct packed {
    logic [7:0] pos3;
    logic [7:0] pos4;
    logic [7:0] pos6;
    logic [7:0] pos8;
    logic [7:0] pos10;
    logic [7:0] pos11;
  } enc_res_t;

  typedef struct packed {
    logic [34:0] av;
    logic        bad_char;
    logic        below_offset;
  } dec_res_t;

  function automatic logic [7:0] digit_to_char(input logic [5:0] d);
    logic [7:0] c;
    c = 8'd0;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (d == 6'(k)) begin
        c = ALPHABET[NUM_SYMS-1-k];
      end
    end
    return c;
  endfunction

  function automatic sym_t char_to_digit(input logic [7:0] c);
    sym_t s;
    s.hit   = 1'b0;
    s.digit = 6'd0;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (c == ALPHABET[NUM_SYMS-1-k]) begin
        s.hit   = 1'b1;
        s.digit = 6'(k);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/av_bv_id_codec.sv
// Top level of the av/BV ID codec: input register, encode/decode logic, result register.
// Depends on avbv_pkg, avbv_encode, avbv_decode, av_bv_id_codec_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | action, av_number, char_pos3..char_pos11
//  out     | out_valid / out_ready| av_result, out_pos3..out_pos11, flags
//
// One request per clock while the result side is not stalled. A request taken in sits in
// the input register, moves through the base-58 logic into the result register, and
// can be taken out from there.
// Reset empties both registers; payload is not reset.
// A stalled result holds the result register; an empty input register still takes a
// request while the result register is full and drains into it when freed.
`include "av_bv_id_codec_assert.svh"

module av_bv_id_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [33:0] av_number,
  input  logic [7:0]  char_pos3,
  input  logic [7:0]  char_pos4,
  input  logic [7:0]  char_pos6,
  input  logic [7:0]  char_pos8,
  input  logic [7:0]  char_pos10,
  input  logic [7:0]  char_pos11,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [34:0] av_result,
  output logic [7:0]  out_pos3,
  output logic [7:0]  out_pos4,
  output logic [7:0]  out_pos6,
  output logic [7:0]  out_pos8,
  output logic [7:0]  out_pos10,
  output logic [7:0]  out_pos11,
  output logic        bad_char,
  output logic        below_offset
);
  import avbv_pkg::*;

  logic        s1_valid;
  logic        s1_action;
  logic [33:0] s1_av;
  logic [7:0]  s1_c3, s1_c4, s1_c6, s1_c8, s1_c10, s1_c11;
  logic        s2_adv;
  enc_res_t    enc;
  dec_res_t    dec;

  assign s2_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_av     <= av_number;
      s1_c3     <= char_pos3;
      s1_c4     <= char_pos4;
      s1_c6     <= char_pos6;
      s1_c8     <= char_pos8;
      s1_c10    <= char_pos10;
      s1_c11    <= char_pos11;
    end
  end

  avbv_encode u_encode (
    .av_number (s1_av),
    .res       (enc)
  );

  avbv_decode u_decode (
    .char_pos3  (s1_c3),
    .char_pos4  (s1_c4),
    .char_pos6  (s1_c6),
    .char_pos8  (s1_c8),
    .char_pos10 (s1_c10),
    .char_pos11 (s1_c11),
    .res        (dec)
  );

  // unused mode's fields go out as zero
  always_ff @(posedge clk) begin
    if (s1_valid && s2_adv) begin
      if (s1_action) begin
        av_result    <= dec.av;
        bad_char     <= dec.bad_char;
        below_offset <= dec.below_offset;
        out_pos3     <= 8'd0;
        out_pos4     <= 8'd0;
        out_pos6     <= 8'd0;
        out_pos8     <= 8'd0;
        out_pos10    <= 8'd0;
        out_pos11    <= 8'd0;
      end else begin
        av_result    <= 35'd0;
        bad_char     <= 1'b0;
        below_offset <= 1'b0;
        out_pos3     <= enc.pos3;
        out_pos4     <= enc.pos4;
        out_pos6     <= enc.pos6;
        out_pos8     <= enc.pos8;
        out_pos10    <= enc.pos10;
        out_pos11    <= enc.pos11;
      end
    end
  end

  `AVBV_ASSERT_RST(a_reset_empty, rst |=> !s1_valid && !out_valid, "pipeline not empty after reset")
  `AVBV_ASSERT(a_s1_held, s1_valid && !s2_adv |=> s1_valid, "input register lost a request")
  `AVBV_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `AVBV_ASSERT(a_flags_decode, out_valid && (bad_char || below_offset) |-> out_pos3 == 8'd0 && out_pos11 == 8'd0, "decode result carries symbols")
  `AVBV_ASSERT(a_av_decode, out_valid && av_result != 35'd0 |-> out_pos6 == 8'd0 && out_pos10 == 8'd0, "decode result carries symbols")

endmodule

>>> rtl/avbv_encode.sv
// Encoder: keyed number to six base-58 symbols at their string positions.
// Depends on avbv_pkg.
module avbv_encode (
  input  logic [33:0]         av_number,
  output avbv_pkg::enc_res_t  res
);
  import avbv_pkg::*;

  // floor(y / 24389) for 32-bit y: y * ceil(2^47 / 24389) >> 47
  localparam logic [32:0] RECIP_P3 = 33'd5770531320;
  // floor(w / 29) for 17-bit w and for 11-bit w
  localparam logic [17:0] RECIP_29_W17 = 18'd144632;
  localparam logic [11:0] RECIP_29_W11 = 12'd2260;

  // three base-58 digits of a value below 58^3, packed {d2, d1, d0}
  function automatic logic [17:0] split3(input logic [17:0] z);
    logic [34:0] p1;
    logic [11:0] q1;
    logic [17:0] r0;
    logic [22:0] p2;
    logic [5:0]  q2;
    logic [11:0] r1;
    p1 = 35'(z[17:1]) * 35'(RECIP_29_W17);
    q1 = p1[33:22];
    r0 = z - 18'(q1) * 18'(RADIX_P1);
    p2 = 23'(q1[11:1]) * 23'(RECIP_29_W11);
    q2 = p2[21:16];
    r1 = q1 - 12'(q2) * 12'(RADIX_P1);
    return {q2, r1[5:0], r0[5:0]};
  endfunction

  logic [34:0] x;
  logic [64:0] prod;
  logic [17:0] hi;
  logic [34:0] hi_w;
  logic [34:0] lo_w;
  logic [17:0] lo_d;
  logic [17:0] hi_d;

  always_comb begin
    x    = {1'b0, av_number ^ KEY_XOR} + KEY_ADD;
    // x / 58^3 = (x >> 3) / 29^3
    prod = 65'(x[34:3]) * 65'(RECIP_P3);
    hi   = prod[64:47];
    hi_w = 35'(hi) * 35'(RADIX_P3);
    lo_w = x - hi_w;
    lo_d = split3(lo_w[17:0]);
    hi_d = split3(hi);
  end

  assign res.pos11 = digit_to_char(lo_d[5:0]);
  assign res.pos10 = digit_to_char(lo_d[11:6]);
  assign res.pos3  = digit_to_char(lo_d[17:12]);
  assign res.pos8  = digit_to_char(hi_d[5:0]);
  assign res.pos4  = digit_to_char(hi_d[11:6]);
  assign res.pos6  = digit_to_char(hi_d[17:12]);

endmodule

>>> rtl/avbv_decode.sv
// Decoder: six ID-string symbols back to the numeric ID, with error flags.
// Depends on avbv_pkg.
module avbv_decode (
  input  logic [7:0]          char_pos3,
  input  logic [7:0]          char_pos4,
  input  logic [7:0]          char_pos6,
  input  logic [7:0]          char_pos8,
  input  logic [7:0]          char_pos10,
  input  logic [7:0]          char_pos11,
  output avbv_pkg::dec_res_t  res
);
  import avbv_pkg::*;

  sym_t        s0, s1, s2, s3, s4, s5;
  logic [35:0] sum;
  logic [35:0] diff;

  always_comb begin
    s0 = char_to_digit(char_pos11);
    s1 = char_to_digit(char_pos10);
    s2 = char_to_digit(char_pos3);
    s3 = char_to_digit(char_pos8);
    s4 = char_to_digit(char_pos4);
    s5 = char_to_digit(char_pos6);
    sum = 36'(s0.digit)
        + 36'(s1.digit) * RADIX_P1
        + 36'(s2.digit) * RADIX_P2
        + 36'(s3.digit) * RADIX_P3
        + 36'(s4.digit) * RADIX_P4
        + 36'(s5.digit) * RADIX_P5;
    diff = sum - 36'(KEY_ADD);
    res.av           = diff[34:0] ^ 35'(KEY_XOR);
    res.bad_char     = !(s0.hit && s1.hit && s2.hit && s3.hit && s4.hit && s5.hit);
    res.below_offset = sum < 36'(KEY_ADD);
  end

endmodule

>>> dv/av_bv_id_codec_tb.sv
// Self-checking testbench for av_bv_id_codec: numeric ID <-> base-58 ID text.
// Needs only the RTL (av_bv_id_codec and what it pulls in); the predictor
// is built into this file.
`timescale 1ns / 1ps

module av_bv_id_codec_tb;

  localparam bit          ACT_ENCODE  = 1'b0;
  localparam bit          ACT_DECODE  = 1'b1;
  localparam logic [33:0] ID_KEY      = 34'd177451812;
  localparam logic [34:0] ID_OFFSET   = 35'd8728348608;
  localparam logic [35:0] TEXT_MAX    = 36'd38068692543;  // 58^6 - 1
  localparam logic [33:0] AV_MAX      = 34'h3_FFFF_FFFF;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 300000;

  // symbol k sits at byte 57-k
  localparam logic [58*8-1:0] SYMBOLS =
    "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";

  typedef struct packed {
    logic [7:0] p3;
    logic [7:0] p4;
    logic [7:0] p6;
    logic [7:0] p8;
    logic [7:0] p10;
    logic [7:0] p11;
  } id_text_t;

  typedef struct packed {
    logic [34:0] av;
    id_text_t    txt;
    logic        bad;
    logic        below;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_ENCODE;
  logic [33:0] av_number = '0;
  logic [7:0]  char_pos3 = '0;
  logic [7:0]  char_pos4 = '0;
  logic [7:0]  char_pos6 = '0;
  logic [7:0]  char_pos8 = '0;
  logic [7:0]  char_pos10 = '0;
  logic [7:0]  char_pos11 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [34:0] av_result;
  logic [7:0]  out_pos3;
  logic [7:0]  out_pos4;
  logic [7:0]  out_pos6;
  logic [7:0]  out_pos8;
  logic [7:0]  out_pos10;
  logic [7:0]  out_pos11;
  logic        bad_char;
  logic        below_offset;

  codec_result_t pending_results[$];
  codec_result_t oldest;
  int            err_count = 0;
  int            cycle_count = 0;
  int            stall_pct = 0;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;

  av_bv_id_codec uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .av_number    (av_number),
    .char_pos3    (char_pos3),
    .char_pos4    (char_pos4),
    .char_pos6    (char_pos6),
    .char_pos8    (char_pos8),
    .char_pos10   (char_pos10),
    .char_pos11   (char_pos11),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .av_result    (av_result),
    .out_pos3     (out_pos3),
    .out_pos4     (out_pos4),
    .out_pos6     (out_pos6),
    .out_pos8     (out_pos8),
    .out_pos10    (out_pos10),
    .out_pos11    (out_pos11),
    .bad_char     (bad_char),
    .below_offset (below_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sym_of(input int k);
    return SYMBOLS[(57-k)*8 +: 8];
  endfunction

  function automatic bit lookup_digit(input logic [7:0] c, output logic [5:0] d);
    d = '0;
    for (int k = 0; k < 58; k++) begin
      if (sym_of(k) == c) begin
        d = 6'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // six base-58 digits, least significant first, land at 11,10,3,8,4,6
  function automatic id_text_t digits_to_text(input logic [35:0] v);
    id_text_t   t;
    logic [7:0] ch;
    t = '0;
    for (int i = 0; i < 6; i++) begin
      ch = sym_of(int'(v % 36'd58));
      v  = v / 36'd58;
      case (i)
        0: t.p11 = ch;
        1: t.p10 = ch;
        2: t.p3  = ch;
        3: t.p8  = ch;
        4: t.p4  = ch;
        default: t.p6 = ch;
      endcase
    end
    return t;
  endfunction

  function automatic codec_result_t predict_codec(input bit act, input logic [33:0] avn,
                                                  input id_text_t txt);
    codec_result_t r;
    logic [7:0]    ch [6];
    logic [5:0]    d;
    logic [35:0]   x;
    logic [63:0]   sum;
    logic [63:0]   weight;
    logic [63:0]   diff;
    r = '0;
    if (act == ACT_ENCODE) begin
      x = {2'b00, avn ^ ID_KEY} + {1'b0, ID_OFFSET};
      r.txt = digits_to_text(x);
    end else begin
      ch[0] = txt.p11;
      ch[1] = txt.p10;
      ch[2] = txt.p3;
      ch[3] = txt.p8;
      ch[4] = txt.p4;
      ch[5] = txt.p6;
      sum = '0;
      weight = 64'd1;
      for (int i = 0; i < 6; i++) begin
        if (!lookup_digit(ch[i], d)) r.bad = 1'b1;
        sum = sum + {58'd0, d} * weight;
        weight = weight * 64'd58;
      end
      diff = sum - {29'd0, ID_OFFSET};
      r.av = diff[34:0] ^ {1'b0, ID_KEY};
      r.below = (sum < {29'd0, ID_OFFSET});
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [34:0] want,
                                      input logic [34:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // one request: hold valid until taken, then queue its prediction
  task automatic send_request(input bit act, input logic [33:0] avn, input id_text_t txt);
    in_valid   <= 1'b1;
    action     <= act;
    av_number  <= avn;
    char_pos3  <= txt.p3;
    char_pos4  <= txt.p4;
    char_pos6  <= txt.p6;
    char_pos8  <= txt.p8;
    char_pos10 <= txt.p10;
    char_pos11 <= txt.p11;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_codec(act, avn, txt));
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        err_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("av_result", oldest.av, av_result);
        check_field("out_pos3", 35'(oldest.txt.p3), 35'(out_pos3));
        check_field("out_pos4", 35'(oldest.txt.p4), 35'(out_pos4));
        check_field("out_pos6", 35'(oldest.txt.p6), 35'(out_pos6));
        check_field("out_pos8", 35'(oldest.txt.p8), 35'(out_pos8));
        check_field("out_pos10", 35'(oldest.txt.p10), 35'(out_pos10));
        check_field("out_pos11", 35'(oldest.txt.p11), 35'(out_pos11));
        check_field("bad_char", 35'(oldest.bad), 35'(bad_char));
        check_field("below_offset", 35'(oldest.below), 35'(below_offset));
      end
    end
  end

  // receiver: random stalls plus a short periodic stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct) && ((cycle_count % 64) >= 5);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_encode_edges();
    send_request(ACT_ENCODE, '0, '0);
    send_request(ACT_ENCODE, AV_MAX, '1);
    send_request(ACT_ENCODE, ID_KEY, '0);
    send_request(ACT_ENCODE, ~ID_KEY, '1);
    send_request(ACT_ENCODE, 34'd170001, '0);
    send_request(ACT_ENCODE, 34'h2_AAAA_AAAA, '0);
    send_request(ACT_ENCODE, 34'h1_5555_5555, '1);
  endtask

  task automatic test_decode_edges();
    id_text_t      t;
    codec_result_t enc_ref;
    send_request(ACT_DECODE, AV_MAX, digits_to_text('0));      // sum zero, below offset
    send_request(ACT_DECODE, '0, digits_to_text(TEXT_MAX));    // largest sum
    send_request(ACT_DECODE, '0, digits_to_text({1'b0, ID_OFFSET}));
    send_request(ACT_DECODE, '0, digits_to_text({1'b0, ID_OFFSET} - 36'd1));
    enc_ref = predict_codec(ACT_ENCODE, 34'd170001, '0);
    send_request(ACT_DECODE, '0, enc_ref.txt);
    send_request(ACT_DECODE, '0, '0);                          // all unknown
    send_request(ACT_DECODE, AV_MAX, '1);
    // one character outside the alphabet at each position in turn
    for (int i = 0; i < 6; i++) begin
      t = digits_to_text(36'd20000000000);
      case (i)
        0: t.p3  = "0";
        1: t.p4  = "I";
        2: t.p6  = "O";
        3: t.p8  = "l";
        4: t.p10 = "-";
        default: t.p11 = 8'h80;
      endcase
      send_request(ACT_DECODE, '0, t);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold_off();
    stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 16; i++)
      send_request(i[0] ? ACT_DECODE : ACT_ENCODE, 34'(i * 7919),
                   digits_to_text(36'(i) * 36'd2379293283));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int rx_stall,
                                     input int max_gap);
    int            sent;
    int            burst;
    int            kind;
    logic [33:0]   avn;
    id_text_t      txt;
    logic [35:0]   v;
    codec_result_t enc_ref;
    stall_pct = rx_stall;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(16, 1);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        avn[31:0]  = $urandom;
        avn[33:32] = 2'($urandom_range(3));
        case ($urandom_range(15))
          0: avn = '0;
          1: avn = AV_MAX;
          default: ;
        endcase
        txt = {16'($urandom_range(65535)), $urandom};
        kind = $urandom_range(9);
        if (kind < 4) begin
          send_request(ACT_ENCODE, avn, txt);
        end else begin
          if (kind < 7) begin
            // well-formed text across the full digit range
            v = {4'($urandom_range(15)), $urandom} % (TEXT_MAX + 36'd1);
            txt = digits_to_text(v);
          end else if (kind == 7) begin
            enc_ref = predict_codec(ACT_ENCODE, avn, '0);
            txt = enc_ref.txt;
          end else if (kind == 8) begin
            // well-formed with one byte broken
            v = {4'($urandom_range(15)), $urandom} % (TEXT_MAX + 36'd1);
            txt = digits_to_text(v);
            txt[8*$urandom_range(5) +: 8] = 8'($urandom_range(255));
          end
          send_request(ACT_DECODE, avn, txt);
        end
        sent++;
      end
      idle_sender($urandom_range(max_gap));
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_edges();
    test_decode_edges();
    wait_drained();
    test_output_hold_off();
    test_random_traffic(500, 0, 0);
    test_random_traffic(700, 30, 4);
    test_random_traffic(700, 70, 8);
    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/avbv_pkg.sv
rtl/avbv_encode.sv
rtl/avbv_decode.sv
rtl/av_bv_id_codec.sv
dv/av_bv_id_codec_tb.sv
